>>> hw/rtl/bea_pkg.sv
package bea_pkg;

  localparam int BAND_COUNT_DEF = 14;
  localparam int WORDS_PER_BAND = 6;

  localparam int CMD_W      = 2;
  localparam int SAMPLE_W   = 16;
  localparam int BSEL_W     = 4;
  localparam int WSEL_W     = 3;
  localparam int TABLE_W    = 32;
  localparam int BIDX_OUT_W = 4;
  localparam int MAG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_CNT_W  = 6;

  localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUBLISH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd2;

  localparam logic [WSEL_W-1:0] W_GAIN = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AGC_ATTACK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AGC_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_GATE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_THR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_HOLD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_AGC_SCALE   = 3'd7;

  localparam logic [23:0] ATTACK_RST      = 24'd16690078;
  localparam logic [23:0] RELEASE_RST     = 24'd16775274;
  localparam logic [23:0] AGC_ATTACK_RST  = 24'd15099494;
  localparam logic [23:0] AGC_RELEASE_RST = 24'd16693330;
  localparam logic [23:0] NOISE_GATE_RST  = 24'd8389;
  localparam logic [23:0] QUIET_THR_RST   = 24'd33554;
  localparam logic [7:0]  QUIET_HOLD_RST  = 8'd20;
  localparam logic [11:0] AGC_SCALE_RST   = 12'd896;

  localparam logic signed [31:0] AGC_RESET_LEVEL = 32'sd167772;
  localparam int SCALE_W = 36;
  localparam logic [SCALE_W-1:0] SCALE_FLOOR = 36'd167772;

  localparam int MUL_W = 33;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/bea_if.sv
interface bea_in_if import bea_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CMD_W-1:0]            command;
  logic signed [SAMPLE_W-1:0]  left_sample;
  logic signed [SAMPLE_W-1:0]  right_sample;
  logic [BSEL_W-1:0]           band_select;
  logic [WSEL_W-1:0]           word_select;
  logic signed [TABLE_W-1:0]   table_value;

  modport source(output valid, command, left_sample, right_sample, band_select,
                 word_select, table_value, input ready);
  modport sink(input valid, command, left_sample, right_sample, band_select,
               word_select, table_value, output ready);
endinterface

interface bea_out_if import bea_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [BIDX_OUT_W-1:0] band_index;
  logic [MAG_W-1:0]      magnitude;
  logic                  quiet;
  logic                  last;

  modport source(output valid, band_index, magnitude, quiet, last, input ready);
  modport sink(input valid, band_index, magnitude, quiet, last, output ready);
endinterface

>>> hw/rtl/bea_mul.sv
module bea_mul import bea_pkg::*; #(
  parameter int AW = MUL_W,
  parameter int BW = MUL_W
) (
  input  logic                     clk,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> hw/rtl/bea_div.sv
module bea_div import bea_pkg::*; #(
  parameter int DW = 37,
  parameter int VW = SCALE_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  div_ctl_t      ctl,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [VW-1:0] rem_init,
  output logic [DW-1:0] quot,
  output div_stat_t     stat
);

  logic [VW-1:0]        rem_r;
  logic [VW-1:0]        dsr_r;
  logic [DW-1:0]        dvd_r;
  logic [DW-1:0]        q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [VW:0]          rem2;
  logic [VW:0]          diff;
  logic                 ge;

  // restoring step: remainder stays below divisor
  assign rem2 = {rem_r, dvd_r[DW-1]};
  assign diff = rem2 - {1'b0, dsr_r};
  assign ge   = (rem2 >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
        rem_r  <= rem_init;
        dsr_r  <= divisor;
        dvd_r  <= dividend;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? diff[VW-1:0] : rem2[VW-1:0];
        dvd_r <= {dvd_r[DW-2:0], 1'b0};
        q_r   <= {q_r[DW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot      = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hw/rtl/band_envelope_agc_analyzer_unit.sv
// Channel   Dir  Payload                                         Transaction
// in_ch     in   command, left/right_sample, band/word_select,   valid & ready
//                table_value
// out_ch    out  band_index, magnitude, quiet, last              valid & ready
// cfg_*     in   cfg_index, cfg_wdata                            cfg_we
//
// Sample: the band walk is set by the issue order on the one shared
//   multiplier (five taps, energy, envelope smoothing per band).
// Publish: paced by the shared divider (one quotient bit per cycle) plus
//   output stalls.
// Reset is synchronous; envelopes are cleared as registers, filter history
//   starts at zero through per-band valid bits, no clearing pass.
// in_ch.ready is low while a transaction is in work; results sit in one
//   output register, so a stalled sink only holds the frame walk.
module band_envelope_agc_analyzer_unit import bea_pkg::*; #(
  parameter int BAND_COUNT = BAND_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bea_in_if.sink                in_ch,
  bea_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int BIDX_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int CA_W   = $clog2(WORDS_PER_BAND * BAND_COUNT);
  localparam int CNT_W  = $clog2(BAND_COUNT + 1);
  localparam int SUM_W  = 31 + CNT_W;
  localparam int PW     = 2 * MUL_W;

  typedef struct packed {
    logic signed [16:0] x1;
    logic signed [16:0] x2;
    logic signed [31:0] y1;
    logic signed [31:0] y2;
  } hist_row_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_MUL, ST_ACC, ST_Y, ST_EM, ST_EF, ST_SM, ST_SF,
    ST_PSUM, ST_PDS, ST_PDIV, ST_PAP, ST_PAM, ST_PAF, ST_PSM, ST_PSF,
    ST_PG, ST_PBD, ST_POUT
  } state_t;

  // configuration
  logic [23:0] attack_r, release_r, agc_att_r, agc_rel_r, gate_r, thr_r;
  logic [7:0]  hold_r;
  logic [11:0] agc_scale_r;

  // sequencer and datapath
  state_t                state_r;
  logic [BIDX_W-1:0]     band_r;
  logic [CA_W-1:0]       base_r;
  logic [WSEL_W-1:0]     word_r;
  logic [2:0]            mk_r;
  logic signed [16:0]    mono_r;
  logic signed [63:0]    acc_r;
  logic signed [31:0]    gain_r;
  logic signed [32:0]    mag_r;
  logic signed [31:0]    en_r;
  logic [23:0]           alpha_r;
  logic signed [32:0]    d_r;
  logic signed [31:0]    env_r [BAND_COUNT];
  logic [BAND_COUNT-1:0] hv_r;
  logic signed [31:0]    ref_r;
  logic [7:0]            qc_r;
  logic                  quiet_r;
  logic [SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]      act_r;
  logic [31:0]           mean_r;
  logic [SCALE_W-1:0]    scale_r;
  logic [MAG_W-1:0]      mag16_r;

  logic                  out_valid_r;
  logic [BIDX_OUT_W-1:0] out_band_r;
  logic [MAG_W-1:0]      out_mag_r;
  logic                  out_quiet_r;
  logic                  out_last_r;

  // memories
  logic signed [31:0] coef_mem [WORDS_PER_BAND * BAND_COUNT];
  logic signed [31:0] coef_q;
  hist_row_t          hist_mem [BAND_COUNT];
  hist_row_t          hist_q;

  logic               in_acc;
  logic               coef_we;
  logic [CA_W-1:0]    coef_waddr;
  logic [CA_W-1:0]    coef_raddr;
  logic [7:0]         waddr_full;
  hist_row_t          hrow;
  hist_row_t          hist_wdata;
  logic               hist_we;
  logic               last_band;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PW-1:0]    prod;

  logic signed [31:0]    env_b;
  logic [31:0]           gated_b;
  logic signed [63:0]    term;
  logic signed [31:0]    y_nxt;
  logic signed [31:0]    energy_nxt;
  logic signed [31:0]    smooth_nxt;
  logic signed [31:0]    refn;
  logic [7:0]            qc_nxt;
  logic [SCALE_W-1:0]    scale_nxt;
  logic signed [31:0]    tgt;

  div_ctl_t              div_ctl;
  div_stat_t             div_stat;
  logic [SUM_W-1:0]      div_dvd;
  logic [SCALE_W-1:0]    div_dsr;
  logic [SCALE_W-1:0]    div_rem;
  logic [SUM_W-1:0]      div_q;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7fffffff;
    if (v < -67'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // (prod + new*2^24 + 2^23) >> 24, the smoother rewritten as a*(old-new)
  function automatic logic signed [31:0] smooth_fin(input logic signed [PW-1:0] p,
                                                    input logic signed [31:0] nv);
    logic signed [66:0] s;
    s = 67'(p) + (67'(nv) <<< 24) + 67'sd8388608;
    return sat32(s >>> 24);
  endfunction

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign last_band = (band_r == BIDX_W'(BAND_COUNT - 1));

  // table load address
  assign waddr_full = 8'(in_ch.band_select) * 8'd6 + 8'(in_ch.word_select);
  assign coef_waddr = CA_W'(waddr_full);
  assign coef_we    = in_acc && (in_ch.command == CMD_LOAD) &&
                      (6'(in_ch.band_select) < 6'(BAND_COUNT)) &&
                      (in_ch.word_select <= W_GAIN);
  assign coef_raddr = base_r + CA_W'(word_r);

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_waddr] <= in_ch.table_value;
    coef_q <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[band_r] <= hist_wdata;
    if (state_r == ST_RD) hist_q <= hist_mem[band_r];
  end

  assign hrow = hv_r[band_r] ? hist_q : '0;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL: begin
        mul_a = MUL_W'(coef_q);
        case (mk_r)
          3'd0:    mul_b = MUL_W'(mono_r);
          3'd1:    mul_b = MUL_W'(hrow.x1);
          3'd2:    mul_b = MUL_W'(hrow.x2);
          3'd3:    mul_b = MUL_W'(hrow.y1);
          default: mul_b = MUL_W'(hrow.y2);
        endcase
      end
      ST_EM: begin
        mul_a = MUL_W'(gain_r);
        mul_b = mag_r;
      end
      ST_SM, ST_PAM: begin
        mul_a = $signed({9'b0, alpha_r});
        mul_b = d_r;
      end
      ST_PSM: begin
        mul_a = MUL_W'(ref_r);
        mul_b = $signed({21'b0, agc_scale_r});
      end
      default: ;
    endcase
  end

  bea_mul #(.AW(MUL_W), .BW(MUL_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // feed-forward taps add, feedback taps subtract at coarser alignment
  assign term = (mk_r <= 3'd3) ? 64'(prod >>> 4) : -64'(prod >>> 12);

  always_comb begin
    logic signed [63:0] t;
    logic signed [32:0] g33;
    t          = (acc_r + 64'sd32768) >>> 16;
    y_nxt      = sat32(67'(t));
    energy_nxt = sat32(67'(prod >>> 28));
    smooth_nxt = smooth_fin(prod, en_r);
    refn       = (smooth_nxt < $signed({8'b0, gate_r})) ? $signed({8'b0, gate_r})
                                                        : smooth_nxt;
    env_b      = env_r[band_r];
    g33        = 33'(env_b) - $signed({9'b0, gate_r});
    gated_b    = (g33 > 33'sd0) ? g33[31:0] : 32'd0;
    if (mean_r < {8'b0, thr_r}) qc_nxt = (qc_r == 8'hff) ? qc_r : qc_r + 8'd1;
    else                        qc_nxt = 8'd0;
    scale_nxt  = SCALE_W'((prod + PW'(128)) >>> 8);
    if (scale_nxt < SCALE_FLOOR) scale_nxt = SCALE_FLOOR;
    tgt        = (mean_r > {8'b0, gate_r}) ? $signed(mean_r) : $signed({8'b0, gate_r});
  end

  assign hist_we    = (state_r == ST_Y);
  assign hist_wdata = '{x1: mono_r, x2: hrow.x1, y1: y_nxt, y2: hrow.y1};

  // shared divider: mean over active bands, then the magnitude of each band neither quiet nor at full scale
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = DIV_CNT_W'(MAG_W);
    div_dvd       = '0;
    div_dsr       = scale_r;
    div_rem       = SCALE_W'(gated_b);
    if (state_r == ST_PDS) begin
      div_ctl.start = (act_r != '0);
      div_ctl.steps = DIV_CNT_W'(SUM_W);
      div_dvd       = sum_r;
      div_dsr       = SCALE_W'(act_r);
      div_rem       = '0;
    end else if (state_r == ST_PG) begin
      div_ctl.start = !quiet_r && (SCALE_W'(gated_b) < scale_r);
    end
  end

  bea_div #(.DW(SUM_W), .VW(SCALE_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .rem_init (div_rem),
    .quot     (div_q),
    .stat     (div_stat)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r    <= ATTACK_RST;
      release_r   <= RELEASE_RST;
      agc_att_r   <= AGC_ATTACK_RST;
      agc_rel_r   <= AGC_RELEASE_RST;
      gate_r      <= NOISE_GATE_RST;
      thr_r       <= QUIET_THR_RST;
      hold_r      <= QUIET_HOLD_RST;
      agc_scale_r <= AGC_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK:      attack_r    <= cfg_wdata;
        REG_RELEASE:     release_r   <= cfg_wdata;
        REG_AGC_ATTACK:  agc_att_r   <= cfg_wdata;
        REG_AGC_RELEASE: agc_rel_r   <= cfg_wdata;
        REG_NOISE_GATE:  gate_r      <= cfg_wdata;
        REG_QUIET_THR:   thr_r       <= cfg_wdata;
        REG_QUIET_HOLD:  hold_r      <= cfg_wdata[7:0];
        REG_AGC_SCALE:   agc_scale_r <= cfg_wdata[11:0];
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      band_r      <= '0;
      base_r      <= '0;
      word_r      <= '0;
      mk_r        <= '0;
      hv_r        <= '0;
      ref_r       <= AGC_RESET_LEVEL;
      qc_r        <= '0;
      quiet_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < BAND_COUNT; i++) env_r[i] <= '0;
    end else begin
      // ST_POUT owns the output register while it walks the frame
      if (out_valid_r && out_ch.ready && (state_r != ST_POUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            band_r <= '0;
            if (in_ch.command == CMD_SAMPLE) begin
              mono_r  <= 17'(in_ch.left_sample) + 17'(in_ch.right_sample);
              word_r  <= '0;
              state_r <= ST_RD;
            end else if (in_ch.command == CMD_PUBLISH) begin
              sum_r   <= '0;
              act_r   <= '0;
              state_r <= ST_PSUM;
            end
          end
        end
        ST_RD: begin
          word_r  <= word_r + 3'd1;
          mk_r    <= '0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          acc_r <= (mk_r == 3'd0) ? 64'sd0 : acc_r + term;
          if (word_r < W_GAIN) word_r <= word_r + 3'd1;
          if (mk_r == 3'd4) state_r <= ST_ACC;
          // term follows the product issued in the cycle before
          mk_r <= mk_r + 3'd1;
        end
        ST_ACC: begin
          acc_r   <= acc_r + term;
          gain_r  <= coef_q;
          state_r <= ST_Y;
        end
        ST_Y: begin
          mag_r          <= (y_nxt < 0) ? -33'(y_nxt) : 33'(y_nxt);
          hv_r[band_r]   <= 1'b1;
          state_r        <= ST_EM;
        end
        ST_EM: state_r <= ST_EF;
        ST_EF: begin
          en_r    <= energy_nxt;
          alpha_r <= (energy_nxt > env_b) ? attack_r : release_r;
          d_r     <= 33'(env_b) - 33'(energy_nxt);
          state_r <= ST_SM;
        end
        ST_SM: state_r <= ST_SF;
        ST_SF: begin
          env_r[band_r] <= smooth_nxt;
          word_r        <= '0;
          if (last_band) begin
            base_r  <= '0;
            state_r <= ST_IDLE;
          end else begin
            base_r  <= base_r + CA_W'(WORDS_PER_BAND);
            band_r  <= band_r + 1'b1;
            state_r <= ST_RD;
          end
        end
        ST_PSUM: begin
          if (gated_b != 32'd0) begin
            sum_r <= sum_r + SUM_W'(gated_b);
            act_r <= act_r + 1'b1;
          end
          if (last_band) state_r <= ST_PDS;
          else band_r <= band_r + 1'b1;
        end
        ST_PDS: begin
          if (act_r == '0) begin
            mean_r  <= '0;
            state_r <= ST_PAP;
          end else begin
            state_r <= ST_PDIV;
          end
        end
        ST_PDIV: begin
          if (div_stat.done) begin
            mean_r  <= 32'(div_q);
            state_r <= ST_PAP;
          end
        end
        ST_PAP: begin
          alpha_r <= ($signed({2'b0, mean_r}) > 34'(ref_r)) ? agc_att_r : agc_rel_r;
          en_r    <= tgt;
          d_r     <= 33'(ref_r) - 33'(tgt);
          state_r <= ST_PAM;
        end
        ST_PAM: state_r <= ST_PAF;
        ST_PAF: begin
          qc_r <= qc_nxt;
          if (qc_nxt >= hold_r) begin
            // quiet run: start over from reset levels
            quiet_r <= 1'b1;
            ref_r   <= AGC_RESET_LEVEL;
            hv_r    <= '0;
            for (int i = 0; i < BAND_COUNT; i++) env_r[i] <= '0;
          end else begin
            quiet_r <= 1'b0;
            ref_r   <= refn;
          end
          state_r <= ST_PSM;
        end
        ST_PSM: state_r <= ST_PSF;
        ST_PSF: begin
          scale_r <= scale_nxt;
          band_r  <= '0;
          state_r <= ST_PG;
        end
        ST_PG: begin
          if (quiet_r) begin
            mag16_r <= '0;
            state_r <= ST_POUT;
          end else if (SCALE_W'(gated_b) >= scale_r) begin
            mag16_r <= '1;
            state_r <= ST_POUT;
          end else begin
            state_r <= ST_PBD;
          end
        end
        ST_PBD: begin
          if (div_stat.done) begin
            mag16_r <= div_q[MAG_W-1:0];
            state_r <= ST_POUT;
          end
        end
        ST_POUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_band_r  <= BIDX_OUT_W'(band_r);
            out_mag_r   <= mag16_r;
            out_quiet_r <= quiet_r;
            out_last_r  <= last_band;
            if (last_band) begin
              band_r  <= '0;
              state_r <= ST_IDLE;
            end else begin
              band_r  <= band_r + 1'b1;
              state_r <= ST_PG;
            end
          end
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.band_index = out_band_r;
  assign out_ch.magnitude  = out_mag_r;
  assign out_ch.quiet      = out_quiet_r;
  assign out_ch.last       = out_last_r;

`ifndef ASSERT_OFF
  a_base_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (base_r == '0))
    else $error("table base not rewound at idle");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == ST_PDIV || state_r == ST_PBD))
    else $error("divider busy outside a divide wait");

  a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.quiet) |-> (out_ch.magnitude == '0))
    else $error("quiet frame with nonzero magnitude");

  a_pub_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.command == CMD_PUBLISH) |=> !in_ch.ready)
    else $error("ready during publish");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bea_pkg::*;

  // Table word selects not named by the package; an unused command code.
  localparam logic [WSEL_W-1:0] W_B0 = 3'd0;
  localparam logic [WSEL_W-1:0] W_B1 = 3'd1;
  localparam logic [WSEL_W-1:0] W_B2 = 3'd2;
  localparam logic [WSEL_W-1:0] W_A1 = 3'd3;
  localparam logic [WSEL_W-1:0] W_A2 = 3'd4;
  localparam logic [CMD_W-1:0]  CMD_NONE = 2'd3;
  localparam int NB = BAND_COUNT_DEF;
  localparam int NUM_PHASES = 5;
  localparam int PHASE_ITEMS = 50;
  // Covers a sample walk or a publish plus stalls, with margin on top.
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [BSEL_W-1:0]          band;
    logic [WSEL_W-1:0]          word;
    logic signed [TABLE_W-1:0]  value;
    logic                       typed;       // publish with hand-written results
    logic [MAG_W-1:0]           typed_mag;
    logic                       typed_quiet;
  } stim_row_t;

  typedef struct packed {
    logic [BIDX_OUT_W-1:0] band_index;
    logic [MAG_W-1:0]      magnitude;
    logic                  quiet;
    logic                  last;
  } band_level_t;

  // Directed table. First two publishes come right after the table load with
  // no samples: nothing is active, so every band reads zero and hold is not met.
  localparam stim_row_t DIRECTED [22] = '{
    '{CMD_PUBLISH, 16'sd0, 16'sd0, 4'd0, W_B0, 32'sd0, 1'b1, 16'd0, 1'b0},
    '{CMD_PUBLISH, 16'sd0, 16'sd0, 4'd0, W_B0, 32'sd0, 1'b1, 16'd0, 1'b0},
    '{CMD_SAMPLE, 16'sh7fff, 16'sh7fff, 4'd0, W_B0, 32'sd0, 1'b0, 16'd0, 1'b0},
    '{CMD_SAMPLE, 16'sh8000, 16'sh8000, 4'd0, W_B0, 32'sd0, 1'b0, 16'd0, 1'b0},
    '{CMD_SAMPLE, 16'sh7fff, 16'sh8000, 4'd0, W_B0, 32'sd0, 1'b0, 16'd0, 1'b0},
    '{CMD_SAMPLE, 16'sd0, 16'sd0, 4'd0, W_B0, 32'sd0, 1'b0, 16'd0, 1'b0},
    '{CMD_PUBLISH, 16'sd0, 16'sd0, 4'd0, W_B0, 32'sd0, 1'b0, 16'd0, 1'b0},
    // out-of-range table addresses: load must be dropped
    '{CMD_LOAD, 16'sd0, 16'sd0, 4'd14, W_B0, 32'sh7fffffff, 1'b0, 16'd0, 1'b0},
    '{CMD_LOAD, 16'sd0, 16'sd0, 4'd15, W_GAIN, 32'sh80000000, 1'b0, 16'd0, 1'b0},
    '{CMD_LOAD, 16'sd0, 16'sd0, 4'd3, 3'd6, 32'sh7fffffff, 1'b0, 16'd0, 1'b0},
    '{CMD_LOAD, 16'sd0, 16'sd0, 4'd3, 3'd7, 32'sh80000000, 1'b0, 16'd0, 1'b0},
    '{CMD_NONE, 16'sh5555, 16'shaaaa, 4'd5, W_B1, 32'sh5555aaaa, 1'b0, 16'd0, 1'b0},
    // negative gain, max gain, most negative b0
    '{CMD_LOAD, 16'sd0, 16'sd0, 4'd0, W_GAIN, -32'sd268435456, 1'b0, 16'd0, 1'b0},
    '{CMD_LOAD, 16'sd0, 16'sd0, 4'd13, W_GAIN, 32'sh7fffffff, 1'b0, 16'd0, 1'b0},
    '{CMD_LOAD, 16'sd0, 16'sd0, 4'd12, W_B0, 32'sh80000000, 1'b0, 16'd0, 1'b0},
    '{CMD_SAMPLE, 16'sh7fff, 16'sh7fff, 4'd0, W_B0, 32'sd0, 1'b0, 16'd0, 1'b0},
    '{CMD_SAMPLE, 16'sh8000, 16'sd0, 4'd0, W_B0, 32'sd0, 1'b0, 16'd0, 1'b0},
    '{CMD_SAMPLE, 16'sd12345, -16'sd999, 4'd0, W_B0, 32'sd0, 1'b0, 16'd0, 1'b0},
    '{CMD_PUBLISH, 16'sd0, 16'sd0, 4'd0, W_B0, 32'sd0, 1'b0, 16'd0, 1'b0},
    '{CMD_LOAD, 16'sd0, 16'sd0, 4'd12, W_B0, 32'sh04000000, 1'b0, 16'd0, 1'b0},
    '{CMD_SAMPLE, -16'sd1, -16'sd1, 4'd0, W_B0, 32'sd0, 1'b0, 16'd0, 1'b0},
    '{CMD_PUBLISH, 16'sd0, 16'sd0, 4'd0, W_B0, 32'sd0, 1'b0, 16'd0, 1'b0}
  };

  // Register settings per random phase, in register index order.
  localparam logic [23:0] PHASE_CFG [NUM_PHASES][8] = '{
    '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 24'd1},
    '{24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
      24'd255, 24'd4095},
    '{24'd8000000, 24'd16000000, 24'd12000000, 24'd16500000, 24'd1000,
      24'hffffff, 24'd0, 24'd300},
    '{24'd16000000, 24'd16700000, 24'd15000000, 24'd16600000, 24'd0,
      24'd500000, 24'd2, 24'd256},
    '{ATTACK_RST, RELEASE_RST, AGC_ATTACK_RST, AGC_RELEASE_RST, NOISE_GATE_RST,
      QUIET_THR_RST, 24'(QUIET_HOLD_RST), 24'(AGC_SCALE_RST)}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bea_in_if  in_ch ();
  bea_out_if out_ch ();

  band_envelope_agc_analyzer_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_SAMPLE;
    in_ch.left_sample = '0;
    in_ch.right_sample = '0;
    in_ch.band_select = '0;
    in_ch.word_select = '0;
    in_ch.table_value = '0;
    out_ch.ready = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the filter bank, envelopes and AGC.
  // ---------------------------------------------------------------------------
  logic signed [31:0] coef_mem [NB*WORDS_PER_BAND];
  longint hist_mem [NB*4];        // x1, x2, y1, y2 per band
  longint env_lvl [NB];
  longint agc_ref;
  int     quiet_run;
  longint reg_val [8];

  band_level_t level_q [$];       // band levels still owed by the DUT
  int  fail_count = 0;
  int  txn_count = 0;
  int  level_count = 0;
  int  quiet_frames = 0;
  bit  steady = 1'b0;             // no idling on either side

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // one-pole smoother, Q0.24 alpha, round half up then floor
  function automatic longint blend(longint a, longint prev, longint nxt);
    longint s;
    s = a * prev + ((64'sd1 <<< 24) - a) * nxt + (64'sd1 <<< 23);
    return clip32(s >>> 24);
  endfunction

  function automatic longint gated(int b);
    longint g;
    g = env_lvl[b] - reg_val[REG_NOISE_GATE];
    return (g > 0) ? g : 64'sd0;
  endfunction

  task automatic model_reset();
    foreach (hist_mem[i]) hist_mem[i] = 0;
    foreach (env_lvl[i]) env_lvl[i] = 0;
    agc_ref = AGC_RESET_LEVEL;
    quiet_run = 0;
    reg_val[REG_ATTACK] = ATTACK_RST;
    reg_val[REG_RELEASE] = RELEASE_RST;
    reg_val[REG_AGC_ATTACK] = AGC_ATTACK_RST;
    reg_val[REG_AGC_RELEASE] = AGC_RELEASE_RST;
    reg_val[REG_NOISE_GATE] = NOISE_GATE_RST;
    reg_val[REG_QUIET_THR] = QUIET_THR_RST;
    reg_val[REG_QUIET_HOLD] = QUIET_HOLD_RST;
    reg_val[REG_AGC_SCALE] = AGC_SCALE_RST;
  endtask

  task automatic filter_mono(longint mono);
    longint c [WORDS_PER_BAND];
    longint acc, y, mag, energy, alpha;
    for (int b = 0; b < NB; b++) begin
      for (int w = 0; w < WORDS_PER_BAND; w++) c[w] = coef_mem[b*WORDS_PER_BAND + w];
      acc = ((c[0] * mono) >>> 4) + ((c[1] * hist_mem[b*4]) >>> 4)
          + ((c[2] * hist_mem[b*4+1]) >>> 4) - ((c[3] * hist_mem[b*4+2]) >>> 12)
          - ((c[4] * hist_mem[b*4+3]) >>> 12);
      y = clip32((acc + (64'sd1 <<< 15)) >>> 16);
      hist_mem[b*4+1] = hist_mem[b*4];
      hist_mem[b*4]   = mono;
      hist_mem[b*4+3] = hist_mem[b*4+2];
      hist_mem[b*4+2] = y;
      mag = (y < 0) ? -y : y;
      energy = clip32((mag * c[5]) >>> 28);
      alpha = (energy > env_lvl[b]) ? reg_val[REG_ATTACK] : reg_val[REG_RELEASE];
      env_lvl[b] = blend(alpha, env_lvl[b], energy);
    end
  endtask

  // End of block: AGC update, quiet detection, then one level per band.
  task automatic publish_frame(bit push);
    longint sum, mean, target, scale, q, alpha;
    int active;
    bit quiet;
    band_level_t lv;
    sum = 0; mean = 0; active = 0;
    for (int b = 0; b < NB; b++) begin
      if (gated(b) > 0) begin
        sum += gated(b);
        active++;
      end
    end
    if (active > 0) mean = sum / active;
    alpha = (mean > agc_ref) ? reg_val[REG_AGC_ATTACK] : reg_val[REG_AGC_RELEASE];
    target = (mean > reg_val[REG_NOISE_GATE]) ? mean : reg_val[REG_NOISE_GATE];
    agc_ref = blend(alpha, agc_ref, target);
    if (agc_ref < reg_val[REG_NOISE_GATE]) agc_ref = reg_val[REG_NOISE_GATE];
    if (mean < reg_val[REG_QUIET_THR]) begin
      if (quiet_run < 255) quiet_run++;
    end else begin
      quiet_run = 0;
    end
    quiet = (quiet_run >= reg_val[REG_QUIET_HOLD]);
    if (quiet) begin
      quiet_frames++;
      agc_ref = AGC_RESET_LEVEL;
      foreach (env_lvl[i]) env_lvl[i] = 0;
      foreach (hist_mem[i]) hist_mem[i] = 0;
    end
    scale = (agc_ref * reg_val[REG_AGC_SCALE] + 128) >>> 8;
    if (scale < longint'(SCALE_FLOOR)) scale = SCALE_FLOOR;
    for (int b = 0; b < NB; b++) begin
      q = 0;
      if (!quiet) begin
        q = (gated(b) * 65536) / scale;
        if (q > 65535) q = 65535;
      end
      lv.band_index = BIDX_OUT_W'(b);
      lv.magnitude = MAG_W'(q);
      lv.quiet = quiet;
      lv.last = (b == NB - 1);
      if (push) level_q.push_back(lv);
    end
  endtask

  task automatic predict(stim_row_t r);
    case (r.cmd)
      CMD_SAMPLE: filter_mono(longint'(r.left) + longint'(r.right));
      CMD_PUBLISH: publish_frame(!r.typed);
      CMD_LOAD: begin
        if (r.band < NB && r.word < WORDS_PER_BAND)
          coef_mem[r.band*WORDS_PER_BAND + r.word] = r.value;
      end
      default: ;
    endcase
  endtask

  // Drives one transaction and holds it until the DUT takes it. Valid is only
  // dropped for an idle gap; back-to-back items keep it high.
  task automatic send(stim_row_t r);
    band_level_t lv;
    while (!steady && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= r.cmd;
    in_ch.left_sample <= r.left;
    in_ch.right_sample <= r.right;
    in_ch.band_select <= r.band;
    in_ch.word_select <= r.word;
    in_ch.table_value <= r.value;
    do @(posedge clk); while (!in_ch.ready);
    txn_count++;
    if (r.cmd == CMD_PUBLISH && r.typed) begin
      for (int b = 0; b < NB; b++) begin
        lv.band_index = BIDX_OUT_W'(b);
        lv.magnitude = r.typed_mag;
        lv.quiet = r.typed_quiet;
        lv.last = (b == NB - 1);
        level_q.push_back(lv);
      end
    end
    predict(r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(int p);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= PHASE_CFG[p][i];
      reg_val[i] = PHASE_CFG[p][i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Coefficients that keep the filter stable: |a1| <= 0.5, |a2| <= 0.25.
  function automatic logic signed [31:0] tame_coef(logic [WSEL_W-1:0] w);
    case (w)
      W_A1:   return 32'($signed($urandom_range(0, 1 << 28)) - (1 << 27));
      W_A2:   return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
      W_GAIN: return 32'($signed($urandom_range(1 << 26, 1 << 30)));
      default: return 32'($signed($urandom_range(0, 1 << 28)) - (1 << 27));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_sample(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 128)) - 64);
      default: return 16'sd0;
    endcase
  endfunction

  function automatic stim_row_t rand_row(int amp_mode);
    stim_row_t r;
    int pick;
    r = '0;
    pick = $urandom_range(99);
    r.left = pick_sample(amp_mode);
    r.right = pick_sample(amp_mode);
    if (pick < 68) begin
      r.cmd = CMD_SAMPLE;
    end else if (pick < 86) begin
      r.cmd = CMD_PUBLISH;
    end else if (pick < 97) begin
      r.cmd = CMD_LOAD;
      // mostly legal addresses; the rest are random and may land past the band or word range
      if ($urandom_range(9) < 8) begin
        r.band = BSEL_W'($urandom_range(NB - 1));
        r.word = WSEL_W'($urandom_range(WORDS_PER_BAND - 1));
      end else begin
        r.band = BSEL_W'($urandom);
        r.word = WSEL_W'($urandom);
      end
      r.value = ($urandom_range(9) < 2) ? 32'($urandom) : tame_coef(r.word);
    end else begin
      r.cmd = CMD_NONE;
      r.band = BSEL_W'($urandom);
      r.word = WSEL_W'($urandom);
      r.value = 32'($urandom);
    end
    return r;
  endfunction

  // Result side: random back-pressure (none while steady), and a check of every accepted level.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        level_count++;
        if (level_q.size() == 0) begin
          $error("band level with nothing expected: band %0d mag %0d",
                 out_ch.band_index, out_ch.magnitude);
          fail_count++;
        end else begin
          automatic band_level_t want = level_q.pop_front();
          if (out_ch.band_index !== want.band_index) begin
            $error("band_index: expected %0d, got %0d", want.band_index, out_ch.band_index);
            fail_count++;
          end
          if (out_ch.magnitude !== want.magnitude) begin
            $error("magnitude: expected %0d, got %0d", want.magnitude, out_ch.magnitude);
            fail_count++;
          end
          if (out_ch.quiet !== want.quiet) begin
            $error("quiet: expected %0d, got %0d", want.quiet, out_ch.quiet);
            fail_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_ch.last);
            fail_count++;
          end
        end
      end
      out_ch.ready <= steady || ($urandom_range(99) >= 6);
    end
  end

  initial begin
    stim_row_t r;
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table before any sample reads it.
    for (int b = 0; b < NB; b++) begin
      for (int w = 0; w < WORDS_PER_BAND; w++) begin
        r = '0;
        r.cmd = CMD_LOAD;
        r.band = BSEL_W'(b);
        r.word = WSEL_W'(w);
        r.value = tame_coef(WSEL_W'(w));
        send(r);
      end
    end

    foreach (DIRECTED[i]) send(DIRECTED[i]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_regs(p);
      steady = (p == NUM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // the low-level phase leans on near-silent input so quiet runs build up
        send(rand_row((p == 3) ? $urandom_range(1, 2) : $urandom_range(0, 2)));
      end
      drain();
    end

    $display("Covered %0d input transactions, %0d band levels checked, %0d quiet frames,",
             txn_count, level_count, quiet_frames);
    $display("over %0d register settings including alpha, gate and hold extremes.",
             NUM_PHASES);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout: %0d band levels still outstanding", level_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
